// ===== design/rsw_pkg.sv =====
// Shared types and constants of the random subsample block.
package rsw_pkg;

  localparam int POP_W = 11;
  localparam int FRAC_W = 17;
  localparam int INDEX_W = 10;
  localparam int WORD_W = 31;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W = 17;
  localparam int EPOCH_W = 8;
  localparam int DIV_CNT_W = 5;
  localparam int DEFAULT_MAX_POPULATION = 1024;

  localparam logic [POP_W-1:0] POP_RESET = 11'd1024;
  localparam logic [FRAC_W-1:0] FRAC_RESET = 17'd65536;

  localparam logic [CFG_INDEX_W-1:0] REG_POPULATION_SIZE = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_FRACTION = 1'd1;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_DRAW = 1'b1;

  localparam logic STATUS_OK = 1'b0;
  localparam logic STATUS_EXHAUSTED = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_RD_CUR,
    ST_RD_K,
    ST_WR_K,
    ST_WR_CUR,
    ST_LOAD
  } rsw_state_t;

  typedef struct packed {
    logic clear_step;
    logic start_load;
    logic div_start;
    logic pend_exhausted;
    logic rd_cur;
    logic rd_k;
    logic wr_k;
    logic wr_cur;
    logic load_result;
  } rsw_cmd_t;

  typedef struct packed {
    logic exhausted;
    logic div_done;
    logic clear_last;
    logic epoch_full;
    logic out_busy;
  } rsw_stat_t;

endpackage

// ===== design/rsw_if.sv =====
// Request and result channel interfaces of the random subsample block.
interface rsw_req_if;
  logic valid;
  logic ready;
  logic command;
  logic [rsw_pkg::WORD_W-1:0] random_word;
  modport source (output valid, command, random_word, input ready);
  modport sink (input valid, command, random_word, output ready);
endinterface

interface rsw_rsp_if;
  logic valid;
  logic ready;
  logic [rsw_pkg::INDEX_W-1:0] sampled_index;
  logic last_draw;
  logic status;
  modport source (output valid, sampled_index, last_draw, status, input ready);
  modport sink (input valid, sampled_index, last_draw, status, output ready);
endinterface

// ===== design/rsw_div.sv =====
// Bit-serial restoring divider that returns the remainder of a draw word.
module rsw_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [rsw_pkg::WORD_W-1:0]  dividend,
  input  logic [rsw_pkg::POP_W-1:0]   divisor,
  output logic                        done,
  output logic [rsw_pkg::POP_W-1:0]   remainder
);
  import rsw_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [WORD_W-1:0]    quot;
  logic [POP_W-1:0]     rem;
  logic [POP_W:0]       trial;
  logic [POP_W:0]       diff;

  assign trial = {rem, quot[WORD_W-1]};
  assign diff = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= DIV_CNT_W'(WORD_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == DIV_CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem <= '0;
    end else if (busy) begin
      quot <= {quot[WORD_W-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        rem <= diff[POP_W-1:0];
      end else begin
        rem <= trial[POP_W-1:0];
      end
    end
  end

  assign done = !busy;
  assign remainder = rem;

endmodule

// ===== design/rsw_ctrl.sv =====
// Controller state machine that sequences starts, draws and clearing passes.
module rsw_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_command,
  input  rsw_pkg::rsw_stat_t stat,
  output rsw_pkg::rsw_cmd_t  cmd,
  output logic               in_ready
);
  import rsw_pkg::*;

  rsw_state_t state;
  rsw_state_t state_next;
  logic       accept;

  assign accept = (state == ST_IDLE) && in_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (stat.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_command == CMD_START) begin
            state_next = stat.epoch_full ? ST_CLEAR : ST_IDLE;
          end else begin
            state_next = stat.exhausted ? ST_LOAD : ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (stat.div_done) state_next = ST_RD_CUR;
      end
      ST_RD_CUR: state_next = ST_RD_K;
      ST_RD_K: state_next = ST_WR_K;
      ST_WR_K: state_next = ST_WR_CUR;
      ST_WR_CUR: state_next = ST_LOAD;
      ST_LOAD: begin
        if (!stat.out_busy) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      ST_CLEAR: cmd.clear_step = 1'b1;
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.start_load = accept && (in_command == CMD_START);
        cmd.div_start = accept && (in_command == CMD_DRAW) && !stat.exhausted;
        cmd.pend_exhausted = accept && (in_command == CMD_DRAW) && stat.exhausted;
      end
      ST_DIV: ;
      ST_RD_CUR: cmd.rd_cur = 1'b1;
      ST_RD_K: cmd.rd_k = 1'b1;
      ST_WR_K: cmd.wr_k = 1'b1;
      ST_WR_CUR: cmd.wr_cur = 1'b1;
      ST_LOAD: cmd.load_result = !stat.out_busy;
      default: cmd = '0;
    endcase
  end

endmodule

// ===== design/rsw_dp.sv =====
// Datapath with configuration, cursor, permutation memory and result register.
module rsw_dp #(
  parameter int MAX_POPULATION = rsw_pkg::DEFAULT_MAX_POPULATION
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             write_enable,
  input  logic [rsw_pkg::CFG_INDEX_W-1:0]  write_index,
  input  logic [rsw_pkg::CFG_DATA_W-1:0]   write_data,
  input  rsw_pkg::rsw_cmd_t                cmd,
  output rsw_pkg::rsw_stat_t               stat,
  input  logic [rsw_pkg::WORD_W-1:0]       random_word,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic [rsw_pkg::INDEX_W-1:0]      out_index,
  output logic                             out_last,
  output logic                             out_status
);
  import rsw_pkg::*;

  localparam int AW = $clog2(MAX_POPULATION);
  localparam int ENTRY_W = EPOCH_W + POP_W;

  logic [POP_W-1:0]   pop_size;
  logic [FRAC_W-1:0]  frac;
  logic [POP_W-1:0]   n_latched;
  logic [POP_W-1:0]   target;
  logic [POP_W-1:0]   cursor;
  logic [EPOCH_W-1:0] epoch;
  logic [AW-1:0]      clr_cnt;

  logic [POP_W-1:0]        n_clamp;
  logic [POP_W+FRAC_W-1:0] product;
  logic [POP_W:0]          m_raw;
  logic [POP_W-1:0]        m_clamp;

  logic             div_done;
  logic [POP_W-1:0] div_rem;
  logic [POP_W-1:0] k;

  logic [ENTRY_W-1:0] mem [MAX_POPULATION];
  logic [ENTRY_W-1:0] rdata;
  logic               mem_we;
  logic [AW-1:0]      waddr;
  logic [ENTRY_W-1:0] wdata;
  logic [AW-1:0]      raddr;

  logic [POP_W-1:0] at_cur;
  logic [POP_W-1:0] at_k;
  logic [POP_W-1:0] entry_val;
  logic [POP_W-1:0] entry_idx;

  logic [INDEX_W-1:0] pend_index;
  logic               pend_last;
  logic               pend_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      pop_size <= POP_RESET;
      frac <= FRAC_RESET;
    end else if (write_enable) begin
      case (write_index)
        REG_POPULATION_SIZE: pop_size <= write_data[POP_W-1:0];
        REG_SAMPLE_FRACTION: frac <= write_data[FRAC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    n_clamp = pop_size;
    if (pop_size == '0) begin
      n_clamp = POP_W'(1);
    end else if (32'(pop_size) > 32'(MAX_POPULATION)) begin
      n_clamp = POP_W'(MAX_POPULATION);
    end
    product = (POP_W+FRAC_W)'(n_clamp) * (POP_W+FRAC_W)'(frac);
    m_raw = product[POP_W+FRAC_W-1:16];
    m_clamp = m_raw[POP_W-1:0];
    if (m_raw == '0) begin
      m_clamp = POP_W'(1);
    end else if (m_raw > {1'b0, n_clamp}) begin
      m_clamp = n_clamp;
    end
  end

  rsw_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (random_word),
    .divisor   (n_latched - cursor),
    .done      (div_done),
    .remainder (div_rem)
  );

  assign k = div_rem + cursor;

  always_ff @(posedge clk) begin
    if (rst) begin
      n_latched <= '0;
      target <= '0;
      cursor <= '0;
      epoch <= '0;
      clr_cnt <= '0;
    end else begin
      if (cmd.start_load) begin
        n_latched <= n_clamp;
        target <= m_clamp;
        cursor <= '0;
        if (!stat.epoch_full) begin
          epoch <= epoch + 1'b1;
        end
      end
      if (cmd.clear_step) begin
        if (stat.clear_last) begin
          clr_cnt <= '0;
          epoch <= EPOCH_W'(1);
        end else begin
          clr_cnt <= clr_cnt + 1'b1;
        end
      end
      if (cmd.wr_cur) begin
        cursor <= cursor + 1'b1;
      end
    end
  end

  always_comb begin
    mem_we = cmd.clear_step || cmd.wr_k || cmd.wr_cur;
    waddr = clr_cnt;
    wdata = '0;
    if (cmd.wr_k) begin
      waddr = AW'(k);
      wdata = {epoch, at_cur};
    end else if (cmd.wr_cur) begin
      waddr = AW'(cursor);
      wdata = {epoch, at_k};
    end
    raddr = cmd.rd_k ? AW'(k) : AW'(cursor);
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd_cur || cmd.rd_k) begin
      rdata <= mem[raddr];
    end
  end

  // An entry tagged with an older epoch has not been written since the last start.
  assign entry_idx = cmd.wr_k ? k : cursor;
  assign entry_val = (rdata[ENTRY_W-1:POP_W] == epoch) ? rdata[POP_W-1:0] : entry_idx;

  always_ff @(posedge clk) begin
    if (cmd.rd_k) begin
      at_cur <= entry_val;
    end
    if (cmd.wr_k) begin
      at_k <= entry_val;
    end
    if (cmd.pend_exhausted) begin
      pend_index <= '0;
      pend_last <= 1'b0;
      pend_status <= STATUS_EXHAUSTED;
    end else if (cmd.wr_cur) begin
      pend_index <= at_k[INDEX_W-1:0];
      pend_last <= (cursor + 1'b1) == target;
      pend_status <= STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_result) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      out_index <= pend_index;
      out_last <= pend_last;
      out_status <= pend_status;
    end
  end

  assign stat.exhausted = (cursor >= target) || (cursor >= n_latched);
  assign stat.div_done = div_done;
  assign stat.clear_last = clr_cnt == AW'(MAX_POPULATION - 1);
  assign stat.epoch_full = &epoch;
  assign stat.out_busy = out_valid && !out_ready;

endmodule

// ===== design/random_subsample_without_replacement.sv =====
// Random subsample without replacement: a start transfer begins a new sample
// of floor(n * fraction) indices, but at least one, out of 0..n-1, and each
// draw transfer returns the next index of a partial Fisher-Yates shuffle
// driven by its random word. A draw runs the bit-serial divider that reduces
// the 31-bit random word modulo the remaining population, followed by two
// reads and two writes of the permutation memory. A draw after the sample is
// complete skips the divider and the memory and returns the exhausted status.
// After reset, and after every 255th start, the block runs a clearing pass
// over all MAX_POPULATION memory entries before it takes the next request;
// configuration writes are accepted at any time.
module random_subsample_without_replacement #(
  parameter int MAX_POPULATION = rsw_pkg::DEFAULT_MAX_POPULATION
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            write_enable,
  input  logic [rsw_pkg::CFG_INDEX_W-1:0] write_index,
  input  logic [rsw_pkg::CFG_DATA_W-1:0]  write_data,
  rsw_req_if.sink                         request,
  rsw_rsp_if.source                       result
);
  import rsw_pkg::*;

  rsw_cmd_t  cmd;
  rsw_stat_t stat;
  logic      in_ready;

  rsw_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (request.valid),
    .in_command (request.command),
    .stat       (stat),
    .cmd        (cmd),
    .in_ready   (in_ready)
  );

  rsw_dp #(
    .MAX_POPULATION (MAX_POPULATION)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .write_index  (write_index),
    .write_data   (write_data),
    .cmd          (cmd),
    .stat         (stat),
    .random_word  (request.random_word),
    .out_ready    (result.ready),
    .out_valid    (result.valid),
    .out_index    (result.sampled_index),
    .out_last     (result.last_draw),
    .out_status   (result.status)
  );

  assign request.ready = in_ready;

endmodule

// ===== tb/sv/tb_random_subsample_without_replacement.sv =====
// Self-checking testbench of the random subsample block, with a shuffle predictor.
module tb_random_subsample_without_replacement;
  timeunit 1ns;
  timeprecision 1ps;
  import rsw_pkg::*;

  localparam int MAX_POP = DEFAULT_MAX_POPULATION;
  localparam int TARGET_ITEMS = 1600;
  localparam int TARGET_STARTS = 300;
  localparam int SETTLE_CYCLES = 48;
  localparam int CYCLE_LIMIT = 800000;
  localparam logic [WORD_W-1:0] WORD_MAX = {WORD_W{1'b1}};

  typedef struct packed {
    logic [INDEX_W-1:0] sampled_index;
    logic last_draw;
    logic status;
  } draw_result_t;

  class subsample_scoreboard;
    logic [INDEX_W-1:0] shuffled [MAX_POP];
    bit moved [MAX_POP];
    logic [POP_W-1:0] population_reg;
    logic [FRAC_W-1:0] fraction_reg;
    int unsigned cursor;
    int unsigned target;
    int unsigned active_n;
    draw_result_t pending_q[$];
    int errors;
    int starts;
    int draws;
    int exhausted;
    int checked;

    function new();
      population_reg = POP_RESET;
      fraction_reg = FRAC_RESET;
      cursor = 0;
      target = 0;
      active_n = 0;
      errors = 0;
      starts = 0;
      draws = 0;
      exhausted = 0;
      checked = 0;
      foreach (moved[i]) moved[i] = 1'b0;
    endfunction

    function int unsigned effective_population(logic [POP_W-1:0] pop);
      int unsigned n;
      n = 32'(pop);
      if (n < 1) n = 1;
      if (n > MAX_POP) n = MAX_POP;
      return n;
    endfunction

    function int unsigned sample_size(logic [POP_W-1:0] pop, logic [FRAC_W-1:0] frac);
      longint unsigned m;
      longint unsigned n;
      n = effective_population(pop);
      m = (n * longint'(frac)) >> 16;
      if (m < 1) m = 1;
      if (m > n) m = n;
      return 32'(m);
    endfunction

    function void write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_POPULATION_SIZE) begin
        population_reg = data[POP_W-1:0];
      end else if (idx == REG_SAMPLE_FRACTION) begin
        fraction_reg = data[FRAC_W-1:0];
      end
    endfunction

    function logic [INDEX_W-1:0] read_slot(int unsigned i);
      return moved[i] ? shuffled[i] : INDEX_W'(i);
    endfunction

    function void note_request(logic cmd, logic [WORD_W-1:0] word);
      int unsigned span;
      int unsigned k;
      logic [INDEX_W-1:0] at_cursor;
      logic [INDEX_W-1:0] at_k;
      draw_result_t r;
      if (cmd == CMD_START) begin
        active_n = effective_population(population_reg);
        target = sample_size(population_reg, fraction_reg);
        cursor = 0;
        foreach (moved[i]) moved[i] = 1'b0;
        starts++;
      end else if (cursor >= target || cursor >= active_n) begin
        r.sampled_index = '0;
        r.last_draw = 1'b0;
        r.status = STATUS_EXHAUSTED;
        pending_q = {pending_q, r};
        exhausted++;
      end else begin
        span = active_n - cursor;
        k = 32'(word) % span + cursor;
        at_cursor = read_slot(cursor);
        at_k = read_slot(k);
        shuffled[k] = at_cursor;
        moved[k] = 1'b1;
        shuffled[cursor] = at_k;
        moved[cursor] = 1'b1;
        r.sampled_index = at_k;
        r.last_draw = (cursor + 1 == target);
        r.status = STATUS_OK;
        pending_q = {pending_q, r};
        draws++;
        cursor++;
      end
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_result(draw_result_t got);
      draw_result_t want;
      checked++;
      if (pending_q.size() == 0) begin
        report($sformatf("result with nothing outstanding: index %0d last %0b status %0b",
                         got.sampled_index, got.last_draw, got.status));
        return;
      end
      want = pending_q.pop_front();
      if (got.sampled_index !== want.sampled_index)
        report($sformatf("sampled_index %0d, expected %0d",
                         got.sampled_index, want.sampled_index));
      if (got.last_draw !== want.last_draw)
        report($sformatf("last_draw %0b, expected %0b", got.last_draw, want.last_draw));
      if (got.status !== want.status)
        report($sformatf("status %0b, expected %0b", got.status, want.status));
    endtask
  endclass

  logic clk;
  logic rst;
  logic write_enable;
  logic [CFG_INDEX_W-1:0] write_index;
  logic [CFG_DATA_W-1:0] write_data;

  rsw_req_if req_ch ();
  rsw_rsp_if rsp_ch ();

  random_subsample_without_replacement u_dut (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .write_index  (write_index),
    .write_data   (write_data),
    .request      (req_ch),
    .result       (rsp_ch)
  );

  subsample_scoreboard sb = new();

  int unsigned cycle_count = 0;
  int burst_left = 0;
  int items_sent = 0;
  int starts_sent = 0;
  int settings_used = 0;
  logic [POP_W-1:0] cur_pop = POP_RESET;
  logic [FRAC_W-1:0] cur_frac = FRAC_RESET;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_random_subsample_without_replacement: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (write_enable) sb.write_register(write_index, write_data);
      if (req_ch.valid && req_ch.ready) sb.note_request(req_ch.command, req_ch.random_word);
      if (rsp_ch.valid && rsp_ch.ready)
        sb.check_result({rsp_ch.sampled_index, rsp_ch.last_draw, rsp_ch.status});
    end
  end

  initial begin
    int unsigned stretch;
    int unsigned mode;
    rsp_ch.ready <= 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      stretch = $urandom_range(20, 300);
      repeat (stretch) begin
        @(posedge clk);
        case (mode)
          0: rsp_ch.ready <= 1'b1;
          1: rsp_ch.ready <= ($urandom_range(0, 9) < 7);
          2: rsp_ch.ready <= ~rsp_ch.ready;
          default: rsp_ch.ready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  function automatic logic [WORD_W-1:0] rand_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return WORD_MAX;
      default: return WORD_W'($urandom);
    endcase
  endfunction

  task automatic send_item(logic cmd, logic [WORD_W-1:0] word);
    int gap;
    if (burst_left == 0) begin
      case ($urandom_range(0, 3))
        0: gap = 0;
        1, 2: gap = $urandom_range(1, 12);
        default: gap = $urandom_range(13, 50);
      endcase
      burst_left = $urandom_range(1, 24);
      if (gap != 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    req_ch.valid <= 1'b1;
    req_ch.command <= cmd;
    req_ch.random_word <= word;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    burst_left--;
    items_sent++;
    if (cmd == CMD_START) starts_sent++;
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (sb.pending_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(logic [POP_W-1:0] pop, logic [FRAC_W-1:0] frac);
    drain();
    write_enable <= 1'b1;
    write_index <= REG_POPULATION_SIZE;
    write_data <= CFG_DATA_W'(pop);
    @(posedge clk);
    write_index <= REG_SAMPLE_FRACTION;
    write_data <= frac;
    @(posedge clk);
    write_enable <= 1'b0;
    cur_pop = pop;
    cur_frac = frac;
    settings_used++;
  endtask

  initial begin
    logic [POP_W-1:0] pop;
    logic [FRAC_W-1:0] frac;
    int unsigned m;
    int unsigned n_draws;
    int unsigned plan;

    req_ch.valid <= 1'b0;
    req_ch.command <= CMD_START;
    req_ch.random_word <= '0;
    write_enable <= 1'b0;
    write_index <= REG_POPULATION_SIZE;
    write_data <= '0;
    rst <= 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // A draw before any start must come back exhausted.
    send_item(CMD_DRAW, WORD_MAX);

    set_config(11'd1, 17'd0);
    send_item(CMD_START, WORD_MAX);
    send_item(CMD_DRAW, '0);
    send_item(CMD_DRAW, rand_word());

    set_config(11'd0, 17'd131071);
    send_item(CMD_START, rand_word());
    send_item(CMD_DRAW, WORD_MAX);
    send_item(CMD_DRAW, rand_word());

    set_config(11'd2047, 17'd1);
    send_item(CMD_START, rand_word());
    send_item(CMD_DRAW, WORD_MAX);
    send_item(CMD_DRAW, '0);

    // A register change in the middle of a sample only counts at the next start.
    set_config(11'd5, 17'd65536);
    send_item(CMD_START, rand_word());
    send_item(CMD_DRAW, rand_word());
    send_item(CMD_DRAW, rand_word());
    set_config(11'd3, 17'd32768);
    repeat (4) send_item(CMD_DRAW, rand_word());

    set_config(11'd1024, 17'd65536);
    send_item(CMD_START, rand_word());
    send_item(CMD_DRAW, '0);
    send_item(CMD_DRAW, WORD_MAX);
    send_item(CMD_START, rand_word());
    send_item(CMD_DRAW, WORD_MAX);
    send_item(CMD_DRAW, WORD_W'(1));

    while (items_sent < TARGET_ITEMS || starts_sent < TARGET_STARTS) begin
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: pop = POP_W'($urandom_range(1, 24));
          5, 6: pop = POP_W'($urandom_range(25, 1024));
          7: pop = POP_W'($urandom_range(1000, 1024));
          8: pop = $urandom_range(0, 1) ? 11'd0 : 11'd1024;
          default: pop = POP_W'($urandom_range(1025, 2047));
        endcase
        case ($urandom_range(0, 9))
          0, 1, 2, 3: frac = FRAC_W'($urandom_range(0, 65536));
          4, 5: frac = 17'd65536;
          6: frac = FRAC_W'($urandom_range(0, 1023));
          7: frac = FRAC_W'($urandom_range(65537, 131071));
          8: frac = 17'd32768;
          default: frac = FRAC_W'($urandom_range(0, 131071));
        endcase
        set_config(pop, frac);
      end
      m = sb.sample_size(cur_pop, cur_frac);
      plan = $urandom_range(0, 9);
      if (plan < 7) begin
        if ($urandom_range(0, 1) == 0) send_item(CMD_START, rand_word());
        send_item(CMD_START, rand_word());
        n_draws = (m <= 40) ? m + $urandom_range(0, 2) : $urandom_range(1, 40);
        repeat (n_draws) send_item(CMD_DRAW, rand_word());
      end else if (plan == 7) begin
        repeat ($urandom_range(1, 8))
          send_item(($urandom_range(0, 9) < 7) ? CMD_DRAW : CMD_START, rand_word());
      end else if (plan == 8) begin
        send_item(CMD_START, rand_word());
        repeat ($urandom_range(0, (m < 8) ? m : 8)) send_item(CMD_DRAW, rand_word());
        send_item(CMD_START, rand_word());
        repeat ($urandom_range(1, 4)) send_item(CMD_DRAW, rand_word());
      end else begin
        repeat ($urandom_range(2, 6)) send_item(CMD_START, rand_word());
        send_item(CMD_DRAW, rand_word());
      end
    end

    drain();
    $display("summary: %0d starts, %0d shuffle draws, %0d exhausted draws, %0d results checked",
             sb.starts, sb.draws, sb.exhausted, sb.checked);
    $display("summary: %0d register settings, clamped and out-of-range values included",
             settings_used);
    if (sb.errors == 0) begin
      $display("tb_random_subsample_without_replacement: clean");
    end else begin
      $display("tb_random_subsample_without_replacement: errors");
    end
    $finish;
  end

endmodule
